// ----- design/rtc_alarm_clock_with_snooze_defines.svh -----
// Assertion macros for the RTC block.
`ifndef RTC_ALARM_CLOCK_WITH_SNOOZE_DEFINES_SVH
`define RTC_ALARM_CLOCK_WITH_SNOOZE_DEFINES_SVH

// Checked outside reset.
`define RTCAS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked in and out of reset.
`define RTCAS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- design/rtcas_pkg.sv -----
package rtcas_pkg;

    localparam int TICK_WIDTH_DEF = 16;

    localparam logic [15:0] TPS_RESET  = 16'd1000;
    localparam logic [16:0] DAY_SECONDS = 17'd86400;
    localparam logic [16:0] DAY_LAST    = 17'd86399;
    localparam logic [5:0]  LIM_HOURS   = 6'd23;
    localparam logic [5:0]  LIM_MINSEC  = 6'd59;

    localparam logic [2:0] ACT_TICK      = 3'd0;
    localparam logic [2:0] ACT_SET_TIME  = 3'd1;
    localparam logic [2:0] ACT_SET_ALARM = 3'd2;
    localparam logic [2:0] ACT_TOGGLE    = 3'd3;
    localparam logic [2:0] ACT_SNOOZE    = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [23:0] bcd_time_in;
        logic [7:0]  snooze_minutes;
    } in_beat_t;

    typedef struct packed {
        logic [21:0] time_bcd;
        logic        time_valid;
        logic [21:0] alarm_bcd;
        logic        alarm_on;
        logic        snooze_active;
        logic        alarm_fired;
        logic        accepted;
    } out_beat_t;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] units;
        logic [5:0] limit;
        logic       cin;
    } pair_req_t;

    typedef struct packed {
        logic       over;
        logic [5:0] value;
        logic [3:0] tens;
        logic [3:0] units;
    } pair_rsp_t;

endpackage

// ----- design/rtcas_pair.sv -----
module rtcas_pair (
    input  rtcas_pkg::pair_req_t req,
    output rtcas_pkg::pair_rsp_t rsp
);

    logic [7:0] bin_val;
    logic [7:0] sum_val;
    logic [5:0] res;
    logic [2:0] tens;
    logic [5:0] units;

    always_comb begin
        bin_val = 8'({req.tens, 3'b000}) + 8'({req.tens, 1'b0}) + 8'(req.units);
        sum_val = bin_val + 8'(req.cin);
        rsp.over = (sum_val > 8'(req.limit));
        res = rsp.over ? 6'd0 : sum_val[5:0];
        if (res >= 6'd50) begin
            tens = 3'd5;
        end else if (res >= 6'd40) begin
            tens = 3'd4;
        end else if (res >= 6'd30) begin
            tens = 3'd3;
        end else if (res >= 6'd20) begin
            tens = 3'd2;
        end else if (res >= 6'd10) begin
            tens = 3'd1;
        end else begin
            tens = 3'd0;
        end
        units = res - 6'({tens, 3'b000}) - 6'({tens, 1'b0});
        rsp.value = res;
        rsp.tens  = 4'(tens);
        rsp.units = units[3:0];
    end

endmodule

// ----- design/rtc_alarm_clock_with_snooze.sv -----
// Channel  | Ports                         | Beat
// ---------+-------------------------------+--------------------------
// input    | s_valid, s_ready, s_data      | action, BCD time, minutes
// result   | m_valid, m_ready, m_data      | time/alarm BCD and flags
// config   | cfg_we, cfg_wdata             | ticks per second
//
// An item passes through accept, execute, finish and load result; when it
// passes a second or sets the time or the alarm, the shared digit-pair
// unit also handles its three BCD pairs after execute, one pair per cycle.
// s_ready is high only in the idle state; one item is in flight at a time.
// A result waiting on m_ready holds the block in its last state.
// aresetn resets all but the data path; ticks per second resets to 1000.
`include "rtc_alarm_clock_with_snooze_defines.svh"

module rtc_alarm_clock_with_snooze #(
    parameter int TICK_WIDTH = rtcas_pkg::TICK_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rtcas_pkg::in_beat_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rtcas_pkg::out_beat_t m_data
);

    localparam int CMP_W = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PAIR,
        S_DONE,
        S_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    rtcas_pkg::in_beat_t    item_reg, item_next;
    logic [15:0]            tps_reg, tps_next;
    logic [TICK_WIDTH-1:0]  tick_reg, tick_next;
    logic [16:0]            secs_reg, secs_next;
    logic [23:0]            time_bcd_reg, time_bcd_next;
    logic                   time_set_reg, time_set_next;
    logic [16:0]            alarm_secs_reg, alarm_secs_next;
    logic [23:0]            alarm_bcd_reg, alarm_bcd_next;
    logic                   alarm_en_reg, alarm_en_next;
    logic                   snooze_reg, snooze_next;
    logic [16:0]            snooze_secs_reg, snooze_secs_next;
    logic [23:0]            work_reg, work_next;
    logic [16:0]            acc_reg, acc_next;
    logic [1:0]             idx_reg, idx_next;
    logic                   carry_reg, carry_next;
    logic                   second_reg, second_next;
    logic                   fired_reg, fired_next;
    logic                   accepted_reg, accepted_next;
    rtcas_pkg::out_beat_t   out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   is_tick;
    logic [1:0]             pair_sel;
    logic [23:0]            pair_src;
    logic [TICK_WIDTH-1:0]  tick_inc;
    logic                   tick_hit;
    rtcas_pkg::pair_req_t   pair_req;
    rtcas_pkg::pair_rsp_t   pair_rsp;

    rtcas_pair u_pair (
        .req (pair_req),
        .rsp (pair_rsp)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        is_tick  = (item_reg.action == rtcas_pkg::ACT_TICK);
        pair_sel = is_tick ? idx_reg : 2'd2 - idx_reg;
        pair_src = is_tick ? work_reg : item_reg.bcd_time_in;
        pair_req.tens  = pair_src[8*pair_sel+4 +: 4];
        pair_req.units = pair_src[8*pair_sel +: 4];
        pair_req.limit = (pair_sel == 2'd2) ? rtcas_pkg::LIM_HOURS : rtcas_pkg::LIM_MINSEC;
        pair_req.cin   = is_tick ? carry_reg : 1'b0;
        tick_inc = tick_reg + TICK_WIDTH'(1);
        tick_hit = (CMP_W'(tick_inc) >= CMP_W'(tps_reg));
    end

    always_comb begin
        state_next       = state_reg;
        item_next        = item_reg;
        tps_next         = cfg_we ? cfg_wdata : tps_reg;
        tick_next        = tick_reg;
        secs_next        = secs_reg;
        time_bcd_next    = time_bcd_reg;
        time_set_next    = time_set_reg;
        alarm_secs_next  = alarm_secs_reg;
        alarm_bcd_next   = alarm_bcd_reg;
        alarm_en_next    = alarm_en_reg;
        snooze_next      = snooze_reg;
        snooze_secs_next = snooze_secs_reg;
        work_next        = work_reg;
        acc_next         = acc_reg;
        idx_next         = idx_reg;
        carry_next       = carry_reg;
        second_next      = second_reg;
        fired_next       = fired_reg;
        accepted_next    = accepted_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && !m_ready;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                fired_next    = 1'b0;
                accepted_next = 1'b1;
                second_next   = 1'b0;
                idx_next      = 2'd0;
                state_next    = S_DONE;
                case (item_reg.action)
                    rtcas_pkg::ACT_TICK: begin
                        if (tick_hit) begin
                            tick_next   = '0;
                            secs_next   = (secs_reg == rtcas_pkg::DAY_LAST) ? 17'd0
                                                                            : secs_reg + 17'd1;
                            second_next = 1'b1;
                            work_next   = time_bcd_reg;
                            carry_next  = 1'b1;
                            state_next  = S_PAIR;
                        end else begin
                            tick_next = tick_inc;
                        end
                    end
                    rtcas_pkg::ACT_SET_TIME, rtcas_pkg::ACT_SET_ALARM: begin
                        work_next  = '0;
                        acc_next   = '0;
                        state_next = S_PAIR;
                    end
                    rtcas_pkg::ACT_TOGGLE: begin
                        alarm_en_next = !alarm_en_reg;
                        if (alarm_en_reg) begin
                            snooze_next = 1'b0;
                        end
                    end
                    rtcas_pkg::ACT_SNOOZE: begin
                        snooze_secs_next = alarm_secs_reg
                                         + 17'({item_reg.snooze_minutes, 6'b000000})
                                         - 17'({item_reg.snooze_minutes, 2'b00});
                        snooze_next = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_PAIR: begin
                carry_next = pair_rsp.over;
                if (!is_tick && pair_rsp.over) begin
                    accepted_next = 1'b0;
                end
                acc_next = (acc_reg << 6) - (acc_reg << 2) + 17'(pair_rsp.value);
                work_next[8*pair_sel +: 8] = {pair_rsp.tens, pair_rsp.units};
                if (idx_reg == 2'd2) begin
                    state_next = S_DONE;
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            S_DONE: begin
                state_next = S_EMIT;
                case (item_reg.action)
                    rtcas_pkg::ACT_TICK: begin
                        if (second_reg) begin
                            time_bcd_next = work_reg;
                            if (alarm_en_reg && !snooze_reg && alarm_secs_reg == secs_reg) begin
                                fired_next = 1'b1;
                            end
                            if (alarm_en_reg && snooze_reg && snooze_secs_reg == secs_reg) begin
                                fired_next  = 1'b1;
                                snooze_next = 1'b0;
                            end
                        end
                    end
                    rtcas_pkg::ACT_SET_TIME: begin
                        if (accepted_reg) begin
                            secs_next     = acc_reg;
                            time_bcd_next = work_reg;
                            time_set_next = 1'b1;
                        end
                    end
                    rtcas_pkg::ACT_SET_ALARM: begin
                        if (accepted_reg) begin
                            alarm_secs_next = acc_reg;
                            alarm_bcd_next  = work_reg;
                            alarm_en_next   = 1'b1;
                            snooze_next     = 1'b0;
                        end
                    end
                    rtcas_pkg::ACT_SNOOZE: begin
                        if (snooze_secs_reg >= rtcas_pkg::DAY_SECONDS) begin
                            snooze_secs_next = snooze_secs_reg - rtcas_pkg::DAY_SECONDS;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    out_next.time_bcd      = time_bcd_reg[21:0];
                    out_next.time_valid    = time_set_reg;
                    out_next.alarm_bcd     = alarm_bcd_reg[21:0];
                    out_next.alarm_on      = alarm_en_reg;
                    out_next.snooze_active = snooze_reg;
                    out_next.alarm_fired   = fired_reg;
                    out_next.accepted      = accepted_reg;
                    out_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        work_reg   <= work_next;
        acc_reg    <= acc_next;
        idx_reg    <= idx_next;
        carry_reg  <= carry_next;
        out_reg    <= out_next;
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            tps_reg         <= rtcas_pkg::TPS_RESET;
            tick_reg        <= '0;
            secs_reg        <= '0;
            time_bcd_reg    <= '0;
            time_set_reg    <= 1'b0;
            alarm_secs_reg  <= '0;
            alarm_bcd_reg   <= '0;
            alarm_en_reg    <= 1'b0;
            snooze_reg      <= 1'b0;
            snooze_secs_reg <= '0;
            second_reg      <= 1'b0;
            fired_reg       <= 1'b0;
            accepted_reg    <= 1'b1;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            tps_reg         <= tps_next;
            tick_reg        <= tick_next;
            secs_reg        <= secs_next;
            time_bcd_reg    <= time_bcd_next;
            time_set_reg    <= time_set_next;
            alarm_secs_reg  <= alarm_secs_next;
            alarm_bcd_reg   <= alarm_bcd_next;
            alarm_en_reg    <= alarm_en_next;
            snooze_reg      <= snooze_next;
            snooze_secs_reg <= snooze_secs_next;
            second_reg      <= second_next;
            fired_reg       <= fired_next;
            accepted_reg    <= accepted_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    `RTCAS_ASSERT(a_secs_in_day,
        (state_reg == S_IDLE) |-> (secs_reg < rtcas_pkg::DAY_SECONDS
            && alarm_secs_reg < rtcas_pkg::DAY_SECONDS
            && snooze_secs_reg < rtcas_pkg::DAY_SECONDS),
        "seconds counter out of day range")
    `RTCAS_ASSERT(a_accept_starts, (s_valid && s_ready) |=> (state_reg == S_EXEC),
        "accepted beat did not start execution")
    `RTCAS_ASSERT(a_pair_idx, (state_reg == S_PAIR) |-> (idx_reg <= 2'd2),
        "digit pair index out of range")
    `RTCAS_ASSERT(a_fire_needs_enable,
        (out_valid_reg && out_reg.alarm_fired) |-> out_reg.alarm_on,
        "alarm fired while disabled")
    `RTCAS_ASSERT_RST(a_reset_clears_out, !aresetn |=> !m_valid, "result valid after reset")

endmodule
